/* rtl/core/q15pid_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q15pid_pkg
// Shared types, register codes and helpers for the Q15 PID controller core.
// ----------------------------------------------------------------------------
package q15pid_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W    = 19;

    typedef logic signed [DATA_W-1:0] q15_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_DELTA_MODE = 3'd3
    } reg_idx_t;

    typedef struct packed {
        q15_t a0;
        q15_t a1;
        q15_t a2;
    } coef_t;

    typedef struct packed {
        q15_t x1;
        q15_t x2;
        q15_t y1;
    } hist_t;

    localparam q15_t Q15_MAX = 16'sh7fff;
    localparam q15_t Q15_MIN = -16'sh8000;

    localparam q15_t GAIN_P_RST = 16'sd5800;
    localparam q15_t GAIN_I_RST = 16'sd300;
    localparam q15_t GAIN_D_RST = 16'sd0;

    function automatic q15_t sat16(input wide_t v);
        q15_t r;
        if (v > wide_t'(Q15_MAX))
            r = Q15_MAX;
        else if (v < wide_t'(Q15_MIN))
            r = Q15_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // a0 = kp+ki+kd, a1 = -(kp+2kd), a2 = kd
    function automatic coef_t derive(input q15_t gp, input q15_t gi, input q15_t gd);
        wide_t s0;
        wide_t s1;
        coef_t c;
        s0   = wide_t'(gp) + wide_t'(gi) + wide_t'(gd);
        s1   = -(wide_t'(gd) + wide_t'(gd) + wide_t'(gp));
        c.a0 = sat16(s0);
        c.a1 = sat16(s1);
        c.a2 = gd;
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/q15pid_calc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q15pid_calc
// Difference-form PID update: three products, feedback term, floor shift
// and output saturation.
// ----------------------------------------------------------------------------
module q15pid_calc (
    input  wire q15pid_pkg::q15_t  sample,
    input  wire q15pid_pkg::hist_t hist,
    input  wire q15pid_pkg::coef_t coef,
    input  wire logic              delta_mode,
    output q15pid_pkg::q15_t       drive
);
    import q15pid_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHIFT  = 15;

    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [ACC_W-1:0]  fb;
    logic signed [ACC_W-1:0]  acc;
    wide_t                    scaled;

    assign p0 = coef.a0 * sample;
    assign p1 = coef.a1 * hist.x1;
    assign p2 = coef.a2 * hist.x2;

    assign fb  = delta_mode ? '0 : (ACC_W'(hist.y1) <<< SHIFT);
    assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + fb;

    // arithmetic shift right, rounds toward minus infinity
    assign scaled = acc[SHIFT +: WIDE_W];
    assign drive  = sat16(scaled);

endmodule
`default_nettype wire

/* rtl/core/q15_pid_controller_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q15_pid_controller_core
// Q15 PID controller in difference form with saturated derived gains.
// ----------------------------------------------------------------------------
// path: an accepted sample is held in the input register, then its drive in the
//   result register, which presents it with out_valid
// throughput: 1 item per cycle while out_ready does not stall the result stage;
//   the y[n-1] feedback closes through the single compute stage (three 16x16 products and a 34-bit sum)
// reset: gains to 5800/300/0, positional mode, history cleared, no item held
// cfg_ready is always high; a gain write clears the history
module q15_pid_controller_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire q15pid_pkg::q15_t                sample,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output q15pid_pkg::q15_t                     drive,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [q15pid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [q15pid_pkg::DATA_W-1:0]         cfg_data
);
    import q15pid_pkg::*;

    q15_t  gain_p_reg;
    q15_t  gain_i_reg;
    q15_t  gain_d_reg;
    logic  delta_mode_reg;
    coef_t coef_reg;
    hist_t hist_reg;
    hist_t hist_next;
    logic  clear_hist;

    logic  s1_valid_reg;
    q15_t  s1_sample_reg;
    logic  out_valid_reg;
    q15_t  drive_reg;
    q15_t  drive_next;
    logic  advance;
    logic  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    assign advance   = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | advance;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            delta_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= cfg_data;
                REG_GAIN_I:     gain_i_reg     <= cfg_data;
                REG_GAIN_D:     gain_d_reg     <= cfg_data;
                REG_DELTA_MODE: delta_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        clear_hist = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: clear_hist = 1'b1;
                default:                            clear_hist = 1'b0;
            endcase
        end
    end

    // derived gains, refreshed every cycle from the gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= derive(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
        else
            coef_reg <= derive(gain_p_reg, gain_i_reg, gain_d_reg);
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_sample_reg <= sample;
    end

    q15pid_calc u_calc (
        .sample     (s1_sample_reg),
        .hist       (hist_reg),
        .coef       (coef_reg),
        .delta_mode (delta_mode_reg),
        .drive      (drive_next)
    );

    always_comb
    begin
        hist_next = hist_reg;
        if (clear_hist)
        begin
            hist_next = '0;
        end
        else if (advance)
        begin
            hist_next.x2 = hist_reg.x1;
            hist_next.x1 = s1_sample_reg;
            if (!delta_mode_reg)
                hist_next.y1 = drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else
            hist_reg <= hist_next;
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            drive_reg <= drive_next;
    end

endmodule
`default_nettype wire
